// File: hdl/mma_pkg.sv
// Shared widths and default sizes for the multichannel moving average.
// No dependencies; imported by mma_divider and multichannel_moving_average.
package mma_pkg;

    // Fixed field widths
    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 20;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int REG_COUNT = 8;

    // Default sizes
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_MAX_WINDOW = 16;

endpackage

// File: hdl/mma_divider.sv
// Serial restoring divider: one quotient bit per cycle over a SUM_W-bit dividend.
// Depends on mma_pkg for the dividend width.
module mma_divider #(
    parameter int DIVISOR_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mma_pkg::SUM_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic                        done,
    output logic [mma_pkg::SUM_W-1:0]   quotient
);
    import mma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 done_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [SUM_W-1:0]     quo_reg;

    logic [DIVISOR_W:0]   shifted;
    logic                 fits;

    // Shift one dividend bit into the remainder and trial-subtract
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= DIVISOR_W'(shifted - {1'b0, dvs_reg});
            else
                rem_reg <= shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/multichannel_moving_average.sv
// Multichannel moving average: per-channel sliding-window mean of 16-bit samples.
// Depends on mma_pkg and mma_divider.
//
// Usage:
//   Input channel (sample_valid/sample_ready) carries channel and sample.
//   Output channel (result_valid/result_ready) carries channel_out, average
//   and window_full, one result transaction per input transaction whose
//   channel is below CHANNELS; other channels are taken and dropped.
//   Configuration: cfg_we with cfg_index/cfg_data writes window_len_<index>,
//   clamped to 1..MAX_WINDOW; the write empties that channel's window.
// Sequence:
//   An item passes from acceptance to a valid result through a ring read,
//   a sum update, the serial divider (one quotient bit at a time), a step to
//   see the divider finish and the load of the output register. sample_ready
//   returns high as the result turns valid, so no new item is taken before then.
// Reset and stall:
//   Reset sets every window length to 1 and empties every window; no clearing
//   pass is needed since unfilled ring slots read as zero via the held count.
//   The result sits in an output register; a new input transaction is taken
//   while it waits, and the next result holds in the sequencer until the
//   register is free.
module multichannel_moving_average #(
    parameter int CHANNELS   = mma_pkg::DEF_CHANNELS,
    parameter int MAX_WINDOW = mma_pkg::DEF_MAX_WINDOW
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  logic [mma_pkg::CH_W-1:0]        channel,
    input  logic [mma_pkg::SAMPLE_W-1:0]    sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [mma_pkg::CH_W-1:0]        channel_out,
    output logic [mma_pkg::SAMPLE_W-1:0]    average,
    output logic                            window_full,
    input  logic                            cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mma_pkg::CFG_W-1:0]       cfg_data
);
    import mma_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int HEAD_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH    = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W    = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CH_IDX_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0]   smp_reg;
    logic                  full_reg;

    logic [CNT_W-1:0]      win_reg  [CHANNELS];
    logic [SUM_W-1:0]      sum_reg  [CHANNELS];
    logic [HEAD_W-1:0]     head_reg [CHANNELS];
    logic [CNT_W-1:0]      cnt_reg  [CHANNELS];

    logic [SAMPLE_W-1:0]   ring_mem [DEPTH];
    logic [SAMPLE_W-1:0]   rd_data_reg;

    logic                  result_valid_reg;
    logic [CH_W-1:0]       channel_out_reg;
    logic [SAMPLE_W-1:0]   average_reg;
    logic                  window_full_reg;

    logic                  in_fire;
    logic                  ch_ok;
    logic                  load_out;
    logic                  cfg_hit;
    logic [CH_IDX_W-1:0]   cfg_ch;
    logic [LEN_W-1:0]      cfg_len;
    logic [ADDR_W-1:0]     mem_addr;

    logic [CNT_W-1:0]      cur_win;
    logic [CNT_W-1:0]      cur_cnt;
    logic [HEAD_W-1:0]     cur_head;
    logic [SUM_W-1:0]      cur_sum;
    logic [SAMPLE_W-1:0]   old_smp;
    logic [SUM_W-1:0]      new_sum;
    logic [CNT_W-1:0]      new_cnt;
    logic [HEAD_W-1:0]     new_head;

    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quot;

    // Handshake decode
    assign sample_ready = (state_reg == S_IDLE);
    assign in_fire      = sample_valid && sample_ready;
    assign ch_ok        = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
    assign load_out     = (state_reg == S_DONE) && (!result_valid_reg || result_ready);
    assign div_start    = (state_reg == S_UPDATE);

    // Clamp the written window length to 1..MAX_WINDOW
    assign cfg_hit = cfg_we && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(CHANNELS));
    assign cfg_ch  = cfg_index[CH_IDX_W-1:0];
    always_comb
    begin
        cfg_len = LEN_W'(cfg_data);
        if (cfg_len == '0)
            cfg_len = LEN_W'(1);
        else if (cfg_len > LEN_W'(MAX_WINDOW))
            cfg_len = LEN_W'(MAX_WINDOW);
    end

    // Per-channel view of the item in work
    assign cur_win  = win_reg[ch_reg];
    assign cur_cnt  = cnt_reg[ch_reg];
    assign cur_head = head_reg[ch_reg];
    assign cur_sum  = sum_reg[ch_reg];
    assign mem_addr = ADDR_W'(ch_reg) * ADDR_W'(MAX_WINDOW) + ADDR_W'(cur_head);

    // Drop the oldest sample only once the window has filled; unfilled slots are zero
    always_comb
    begin
        old_smp = (cur_cnt == cur_win) ? rd_data_reg : '0;
        new_sum = cur_sum - SUM_W'(old_smp) + SUM_W'(smp_reg);
        new_cnt = (cur_cnt < cur_win) ? cur_cnt + CNT_W'(1) : cur_cnt;
        if (CNT_W'(cur_head) + CNT_W'(1) == cur_win)
            new_head = '0;
        else
            new_head = cur_head + HEAD_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && ch_ok)
                    state_next = S_READ;
            end
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ch_reg  <= channel[CH_IDX_W-1:0];
            smp_reg <= sample;
        end
        if (state_reg == S_UPDATE)
            full_reg <= (new_cnt == cur_win);
    end

    // Sample ring: read the oldest slot, then overwrite it
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_data_reg <= ring_mem[mem_addr];
        if (state_reg == S_UPDATE)
            ring_mem[mem_addr] <= smp_reg;
    end

    // Per-channel window state: config write empties, an item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                win_reg[i]  <= CNT_W'(1);
                sum_reg[i]  <= '0;
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (cfg_hit && (cfg_ch == CH_IDX_W'(i)))
                begin
                    win_reg[i]  <= CNT_W'(cfg_len);
                    sum_reg[i]  <= '0;
                    head_reg[i] <= '0;
                    cnt_reg[i]  <= '0;
                end
                else if ((state_reg == S_UPDATE) && (ch_reg == CH_IDX_W'(i)))
                begin
                    sum_reg[i]  <= new_sum;
                    head_reg[i] <= new_head;
                    cnt_reg[i]  <= new_cnt;
                end
            end
        end
    end

    // Divide the new sum by the held count
    mma_divider #(
        .DIVISOR_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (new_sum),
        .divisor  (new_cnt),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Output register: hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_out)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            channel_out_reg <= CH_W'(ch_reg);
            average_reg     <= div_quot[SAMPLE_W-1:0];
            window_full_reg <= full_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign channel_out  = channel_out_reg;
    assign average      = average_reg;
    assign window_full  = window_full_reg;

endmodule
